// File: hw/rtl/lcmaw_pkg.sv
// Shared constants, types and codes of the load cell moving average weigher.
`default_nettype none
package lcmaw_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int WINDOW     = 16;
   localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
   localparam int DIV_W      = $clog2(WINDOW + 1);
   localparam int CNT_W      = $clog2(SUM_W);
   localparam int SCALE_W    = 24;
   localparam int WEIGHT_W   = 40;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(3998);
   localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(WINDOW - 1);
   localparam logic [DIV_W-1:0]   DIV_FULL    = DIV_W'(WINDOW);
   localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(SUM_W - 1);

   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_ADDR = CSR_ADDR_W'(0);

   localparam logic FUNC_CAPTURE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_MULT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/lcmaw_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lcmaw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire                                         clock,
   input  wire                                         wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                            wr_data,
   input  wire                                         rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lcmaw_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
`default_nettype none
module lcmaw_div
   import lcmaw_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   trial_diff;
   logic             trial_ge;

   always_comb begin
      trial      = {rem_ff, quo_ff[SUM_W-1]};
      trial_ge   = (trial >= {1'b0, dvs_ff});
      trial_diff = trial - {1'b0, dvs_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      priority if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], trial_ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// File: hw/rtl/load_cell_moving_average_weigher_top.sv
// A new request is taken only in the idle state; req_stall is high while one is being
// handled by the ring update, the bit-serial averaging divider and result formation.
// The sample ring is read at acceptance and written back in the following cycle.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears sum, slot, fill flag and tare, and sets
// the scale to 3998; the sample ring is not cleared.
`default_nettype none
module load_cell_moving_average_weigher_top
   import lcmaw_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire                   req_func,
   input  wire  [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [SAMPLE_W-1:0]   rsp_average,
   output logic [WEIGHT_W-1:0]   rsp_weight,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0] csr_paddr,
   input  wire  [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 full_ff, full_in;
   logic [SAMPLE_W-1:0]  tare_ff, tare_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic                 func_ff, func_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [SAMPLE_W-1:0]  avg_ff, avg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_average_ff, rsp_average_in;
   logic [WEIGHT_W-1:0]  rsp_weight_ff, rsp_weight_in;

   logic                 req_accept;
   logic                 out_free;
   logic                 csr_write;
   logic                 ram_wr_en;
   logic [SAMPLE_W-1:0]  ram_rd_data;
   logic [SUM_W-1:0]     evict;
   logic [SAMPLE_W-1:0]  net;
   logic [WEIGHT_W-1:0]  product;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_SCALE_ADDR) ? CSR_DATA_W'(scale_ff) : '0;

   lcmaw_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(slot_ff),
      .wr_data(sample_ff),
      .rd_en  (req_accept),
      .rd_addr(slot_ff),
      .rd_data(ram_rd_data)
   );

   lcmaw_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   assign evict   = full_ff ? SUM_W'(ram_rd_data) : '0;
   assign net     = (avg_ff > tare_ff) ? (avg_ff - tare_ff) : '0;
   assign product = WEIGHT_W'(net) * WEIGHT_W'(scale_ff);

   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      sum_in         = sum_ff;
      full_in        = full_ff;
      tare_in        = tare_ff;
      scale_in       = csr_write ? csr_pwdata[SCALE_W-1:0] : scale_ff;
      func_in        = func_ff;
      sample_in      = sample_ff;
      avg_in         = avg_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_average_in = rsp_average_ff;
      rsp_weight_in  = rsp_weight_ff;
      ram_wr_en      = 1'b0;
      div_req        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in   = req_func;
               sample_in = req_sample;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ram_wr_en      = 1'b1;
            sum_in         = sum_ff - evict + SUM_W'(sample_ff);
            full_in        = full_ff || (slot_ff == SLOT_LAST);
            slot_in        = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
            div_req.start    = 1'b1;
            div_req.dividend = sum_in;
            div_req.divisor  = full_in ? DIV_FULL : DIV_W'(slot_ff) + DIV_W'(1);
            state_in       = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient[SAMPLE_W-1:0];
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = avg_ff;
               rsp_weight_in  = product;
               if (func_ff == FUNC_CAPTURE) begin
                  tare_in = avg_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         sum_ff       <= '0;
         full_ff      <= 1'b0;
         tare_ff      <= '0;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         full_ff      <= full_in;
         tare_ff      <= tare_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      sample_ff      <= sample_in;
      avg_ff         <= avg_in;
      rsp_average_ff <= rsp_average_in;
      rsp_weight_ff  <= rsp_weight_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_weight  = rsp_weight_ff;

`ifndef SYNTHESIS
   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_UPDATE))
      else $error("accepted request did not move to ring update");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

   a_hold_when_out_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MULT) && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_MULT))
      else $error("result left while output register was occupied");

   a_tare_only_at_result: assert property (@(posedge clock) disable iff (reset)
      !$stable(tare_ff) |-> ($past(state_ff) == ST_MULT))
      else $error("tare changed outside result formation");
`endif

endmodule
`default_nettype wire
